### sv/mtcp_pkg.sv
package mtcp_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] transaction_id;
        logic [15:0] protocol_id;
        logic [15:0] length_field;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] address;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_EMIT,
        S_RDREQ,
        S_RDWAIT
    } state_t;

    localparam logic [1:0] OP_REQ   = 2'd0;
    localparam logic [1:0] OP_LD_DI = 2'd1;
    localparam logic [1:0] OP_LD_IR = 2'd2;

    localparam logic [7:0] FC_RD_COIL = 8'h01;
    localparam logic [7:0] FC_RD_DI   = 8'h02;
    localparam logic [7:0] FC_RD_HOLD = 8'h03;
    localparam logic [7:0] FC_RD_IR   = 8'h04;
    localparam logic [7:0] FC_WR_COIL = 8'h05;
    localparam logic [7:0] FC_WR_HOLD = 8'h06;
    localparam logic [7:0] FC_EXC_FLAG = 8'h80;

    localparam logic [7:0] EXC_NONE = 8'h00;
    localparam logic [7:0] EXC_FUNC = 8'h01;
    localparam logic [7:0] EXC_ADDR = 8'h02;
    localparam logic [7:0] EXC_DATA = 8'h03;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam logic [5:0] HDR_BYTES = 6'd8;

endpackage

### sv/mtcp_ram.sv
module mtcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/modbus_tcp_slave_responder.sv
// Modbus TCP responder for function codes 1 to 6.
// Input channel req (req_valid/req_ready) carries one parsed request or one
// host load of a discrete input bit or an input register. Output channel rsp
// (rsp_valid/rsp_ready) carries the response frame one byte per beat, with
// last set on the final byte: 7 header bytes, the function code, then the body.
// Loads and unused operation codes produce no beats.
// A request is accepted, then decoded and executed, then the fixed bytes follow
// (header, function code, byte count, exception code or write echo), one per
// cycle while the receiver does not stall. Every table lives in a RAM with a
// registered read port, so a register read steps through decide, read issue,
// read data and two beats, and each packed byte of coils or discrete inputs
// through decide, a read issue and read data per bit, then a beat.
// The next item is accepted once the last byte sits in the output register.
// After reset a clearing pass writes zero to every table entry, one entry per
// cycle over max(COIL_COUNT, REG_COUNT) addresses; req_ready is low meanwhile.
// When the receiver stalls, the output register holds its byte and generation
// of the next byte waits.
module modbus_tcp_slave_responder #(
    parameter int COIL_COUNT = 128,
    parameter int REG_COUNT  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mtcp_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mtcp_pkg::rsp_t       rsp
);

    localparam int CA    = $clog2(COIL_COUNT);
    localparam int RA    = $clog2(REG_COUNT);
    localparam int CLR_N = (COIL_COUNT > REG_COUNT) ? COIL_COUNT : REG_COUNT;
    localparam int CW    = $clog2(CLR_N);
    localparam int KW    = $clog2(CLR_N + 1);

    mtcp_pkg::state_t state_reg, state_next;
    mtcp_pkg::req_t   req_reg;
    logic [5:0]       idx_reg, idx_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             have_reg, have_next;
    logic [7:0]       acc_reg, acc_next;
    logic [15:0]      word_reg, word_next;
    logic             out_valid_reg, out_valid_next;
    mtcp_pkg::rsp_t   out_reg, out_next;
    logic [CW-1:0]    clr_reg, clr_next;

    // Decode
    logic [16:0] sum17;
    logic [7:0]  exc;
    logic        is_bit, is_reg, is_wr, is_exc;
    logic [5:0]  nb, blen, bp;
    logic [15:0] hdrlen;
    logic [7:0]  fc_out, fixed_byte;
    logic        slot_free, load_out, is_last, clearing;

    // RAM ports
    logic          coil_we, disc_we, hold_we, inp_we;
    logic [CA-1:0] bit_waddr, bit_raddr;
    logic [RA-1:0] reg_waddr, reg_raddr;
    logic          coil_q, disc_q, bit_q;
    logic [15:0]   hold_q, inp_q, reg_q;

    always_comb
    begin
        sum17  = {1'b0, req_reg.address} + {1'b0, req_reg.value};
        exc    = mtcp_pkg::EXC_NONE;
        is_bit = 1'b0;
        is_reg = 1'b0;
        is_wr  = 1'b0;
        unique case (req_reg.function_code)
            mtcp_pkg::FC_RD_COIL, mtcp_pkg::FC_RD_DI:
            begin
                is_bit = 1'b1;
                if (req_reg.value == 16'd0 || 17'(req_reg.value) > 17'(COIL_COUNT))
                    exc = mtcp_pkg::EXC_DATA;
                else if (sum17 > 17'(COIL_COUNT))
                    exc = mtcp_pkg::EXC_ADDR;
            end
            mtcp_pkg::FC_RD_HOLD, mtcp_pkg::FC_RD_IR:
            begin
                is_reg = 1'b1;
                if (req_reg.value == 16'd0 || 17'(req_reg.value) > 17'(REG_COUNT))
                    exc = mtcp_pkg::EXC_DATA;
                else if (sum17 > 17'(REG_COUNT))
                    exc = mtcp_pkg::EXC_ADDR;
            end
            mtcp_pkg::FC_WR_COIL:
            begin
                is_wr = 1'b1;
                if (17'(req_reg.address) >= 17'(COIL_COUNT))
                    exc = mtcp_pkg::EXC_ADDR;
                else if (req_reg.value != mtcp_pkg::COIL_ON
                         && req_reg.value != mtcp_pkg::COIL_OFF)
                    exc = mtcp_pkg::EXC_DATA;
            end
            mtcp_pkg::FC_WR_HOLD:
            begin
                is_wr = 1'b1;
                if (17'(req_reg.address) >= 17'(REG_COUNT))
                    exc = mtcp_pkg::EXC_ADDR;
            end
            default:
            begin
                exc = mtcp_pkg::EXC_FUNC;
            end
        endcase
        is_exc = (exc != mtcp_pkg::EXC_NONE);

        nb = 6'(({1'b0, req_reg.value} + 17'd7) >> 3);
        if (is_exc)
        begin
            blen   = 6'd1;
            hdrlen = 16'd3;
            fc_out = req_reg.function_code | mtcp_pkg::FC_EXC_FLAG;
        end
        else if (is_wr)
        begin
            blen   = 6'd4;
            hdrlen = req_reg.length_field;
            fc_out = req_reg.function_code;
        end
        else if (is_bit)
        begin
            blen   = 6'd1 + nb;
            hdrlen = 16'd3 + 16'(nb);
            fc_out = req_reg.function_code;
        end
        else
        begin
            blen   = 6'd1 + {req_reg.value[4:0], 1'b0};
            hdrlen = 16'd3 + {req_reg.value[14:0], 1'b0};
            fc_out = req_reg.function_code;
        end
        bp      = idx_reg - mtcp_pkg::HDR_BYTES;
        is_last = (idx_reg == mtcp_pkg::HDR_BYTES + blen - 6'd1);

        unique case (idx_reg)
            6'd0: fixed_byte = req_reg.transaction_id[15:8];
            6'd1: fixed_byte = req_reg.transaction_id[7:0];
            6'd2: fixed_byte = req_reg.protocol_id[15:8];
            6'd3: fixed_byte = req_reg.protocol_id[7:0];
            6'd4: fixed_byte = hdrlen[15:8];
            6'd5: fixed_byte = hdrlen[7:0];
            6'd6: fixed_byte = req_reg.unit_id;
            6'd7: fixed_byte = fc_out;
            6'd8:
            begin
                if (is_exc)
                    fixed_byte = exc;
                else if (is_wr)
                    fixed_byte = req_reg.address[15:8];
                else if (is_bit)
                    fixed_byte = 8'(nb);
                else
                    fixed_byte = {req_reg.value[6:0], 1'b0};
            end
            6'd9:  fixed_byte = req_reg.address[7:0];
            6'd10: fixed_byte = req_reg.value[15:8];
            6'd11: fixed_byte = req_reg.value[7:0];
            default: fixed_byte = 8'd0;
        endcase
    end

    assign slot_free = !out_valid_reg || rsp_ready;
    assign clearing  = (state_reg == mtcp_pkg::S_CLEAR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtcp_pkg::S_CLEAR:
            begin
                if (clr_reg == CW'(CLR_N - 1))
                    state_next = mtcp_pkg::S_IDLE;
            end
            mtcp_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = mtcp_pkg::S_EXEC;
            end
            mtcp_pkg::S_EXEC:
            begin
                state_next = (req_reg.operation == mtcp_pkg::OP_REQ)
                             ? mtcp_pkg::S_EMIT : mtcp_pkg::S_IDLE;
            end
            mtcp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    if (idx_reg >= 6'd9 && !is_exc && !is_wr && !have_reg)
                        state_next = mtcp_pkg::S_RDREQ;
                    else if (is_last)
                        state_next = mtcp_pkg::S_IDLE;
                end
            end
            mtcp_pkg::S_RDREQ:
            begin
                state_next = mtcp_pkg::S_RDWAIT;
            end
            mtcp_pkg::S_RDWAIT:
            begin
                if (is_reg || k_reg[2:0] == 3'd7
                    || 16'(k_reg) + 16'd1 == req_reg.value)
                    state_next = mtcp_pkg::S_EMIT;
                else
                    state_next = mtcp_pkg::S_RDREQ;
            end
            default:
            begin
                state_next = mtcp_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        idx_next       = idx_reg;
        k_next         = k_reg;
        have_next      = have_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        load_out       = 1'b0;

        unique case (state_reg)
            mtcp_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + CW'(1);
            end
            mtcp_pkg::S_EXEC:
            begin
                idx_next  = 6'd0;
                k_next    = '0;
                have_next = 1'b0;
                acc_next  = 8'd0;
            end
            mtcp_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    if (idx_reg < 6'd9 || is_exc || is_wr)
                    begin
                        load_out           = 1'b1;
                        out_next.data_byte = fixed_byte;
                    end
                    else if (have_reg)
                    begin
                        load_out = 1'b1;
                        if (is_bit)
                        begin
                            out_next.data_byte = acc_reg;
                            acc_next           = 8'd0;
                            have_next          = 1'b0;
                        end
                        else if (bp[0])
                        begin
                            out_next.data_byte = word_reg[15:8];
                        end
                        else
                        begin
                            out_next.data_byte = word_reg[7:0];
                            have_next          = 1'b0;
                            k_next             = k_reg + KW'(1);
                        end
                    end
                    if (load_out)
                    begin
                        out_next.last  = is_last;
                        out_valid_next = 1'b1;
                        idx_next       = idx_reg + 6'd1;
                    end
                end
            end
            mtcp_pkg::S_RDWAIT:
            begin
                have_next = 1'b1;
                if (is_bit)
                begin
                    if (state_next == mtcp_pkg::S_RDREQ)
                        have_next = 1'b0;
                    acc_next = acc_reg | (8'(bit_q) << k_reg[2:0]);
                    k_next   = k_reg + KW'(1);
                end
                else
                begin
                    word_next = reg_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req_ready = (state_reg == mtcp_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Table access; the clearing pass owns the write ports after reset.
    assign bit_waddr = clearing ? clr_reg[CA-1:0] : req_reg.address[CA-1:0];
    assign reg_waddr = clearing ? clr_reg[RA-1:0] : req_reg.address[RA-1:0];
    assign bit_raddr = req_reg.address[CA-1:0] + k_reg[CA-1:0];
    assign reg_raddr = req_reg.address[RA-1:0] + k_reg[RA-1:0];

    assign coil_we = clearing
                     || (state_reg == mtcp_pkg::S_EXEC && req_reg.operation == mtcp_pkg::OP_REQ
                         && req_reg.function_code == mtcp_pkg::FC_WR_COIL && !is_exc);
    assign hold_we = clearing
                     || (state_reg == mtcp_pkg::S_EXEC && req_reg.operation == mtcp_pkg::OP_REQ
                         && req_reg.function_code == mtcp_pkg::FC_WR_HOLD && !is_exc);
    assign disc_we = clearing
                     || (state_reg == mtcp_pkg::S_EXEC
                         && req_reg.operation == mtcp_pkg::OP_LD_DI
                         && 17'(req_reg.address) < 17'(COIL_COUNT));
    assign inp_we  = clearing
                     || (state_reg == mtcp_pkg::S_EXEC
                         && req_reg.operation == mtcp_pkg::OP_LD_IR
                         && 17'(req_reg.address) < 17'(REG_COUNT));

    assign bit_q = (req_reg.function_code == mtcp_pkg::FC_RD_COIL) ? coil_q : disc_q;
    assign reg_q = (req_reg.function_code == mtcp_pkg::FC_RD_HOLD) ? hold_q : inp_q;

    mtcp_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_coil_ram (
        .clk   (clk),
        .we    (coil_we),
        .waddr (bit_waddr),
        .wdata (!clearing && req_reg.value == mtcp_pkg::COIL_ON),
        .raddr (bit_raddr),
        .rdata (coil_q)
    );

    mtcp_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_disc_ram (
        .clk   (clk),
        .we    (disc_we),
        .waddr (bit_waddr),
        .wdata (!clearing && req_reg.value[0]),
        .raddr (bit_raddr),
        .rdata (disc_q)
    );

    mtcp_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_hold_ram (
        .clk   (clk),
        .we    (hold_we),
        .waddr (reg_waddr),
        .wdata (clearing ? 16'd0 : req_reg.value),
        .raddr (reg_raddr),
        .rdata (hold_q)
    );

    mtcp_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_inp_ram (
        .clk   (clk),
        .we    (inp_we),
        .waddr (reg_waddr),
        .wdata (clearing ? 16'd0 : req_reg.value),
        .raddr (reg_raddr),
        .rdata (inp_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtcp_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        idx_reg  <= idx_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    a_emit_is_request: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtcp_pkg::S_EMIT |-> req_reg.operation == mtcp_pkg::OP_REQ)
        else $error("frame generation for a load operation");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_next.last) |=> state_reg == mtcp_pkg::S_IDLE)
        else $error("frame continues after last byte");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtcp_pkg::S_EMIT |-> idx_reg < mtcp_pkg::HDR_BYTES + blen)
        else $error("byte index beyond frame length");

endmodule
